// ===== sv/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared constants and helpers for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

  typedef logic [2:0] status_t;

  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_SHORT     = 3'd1;
  localparam status_t STATUS_CHECKSUM  = 3'd2;
  localparam status_t STATUS_VERSION   = 3'd3;
  localparam status_t STATUS_HDR_LEN   = 3'd4;
  localparam status_t STATUS_TOTAL_LEN = 3'd5;
  localparam status_t STATUS_FRAGMENT  = 3'd6;

  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
  localparam logic [15:0] COUNT_MAX        = 16'hffff;
  localparam logic [15:0] MORE_FRAGMENTS   = 16'h2000;
  localparam logic [15:0] OFFSET_MASK      = 16'h1fff;
  localparam logic [15:0] CSUM_GOOD        = 16'hffff;
  localparam logic [3:0]  IP_VERSION       = 4'd4;

  // 16-bit ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// ===== sv/ipv4_header_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_checker
// Byte-stream IPv4 header validation with field extraction.
// ----------------------------------------------------------------------------
// Takes one packet byte per transaction, wire order, last_byte set on the
// final byte, and accepts a byte every cycle unless a final byte is held in
// the input register behind a pending result. Each byte is registered, then
// updates the byte count, the captured header fields and a single 16-bit
// ones-complement adder running over the header words; that adder and the
// field capture sit between the input register and the state/result
// registers. On the final byte one result transaction carries the first
// failing check (short, checksum, version, header length, total length,
// fragment; zero if all pass) plus protocol, lengths and addresses. The
// result registers and out_valid load when the final byte leaves the input
// register; a pending result does not stall the stream until a second final
// byte arrives behind it. Header fields never received read as zero, and the
// byte count saturates at 65535.

module ipv4_header_checker
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  protocol,
  output logic [15:0] total_length,
  output logic [5:0]  header_length,
  output logic [31:0] source_address,
  output logic [31:0] destination_address
);

  // input register
  logic       vld;
  logic [7:0] byte_reg;
  logic       last_reg;
  logic       advance;

  // packet state
  logic [15:0] byte_count;
  logic [15:0] sum_acc;
  logic [7:0]  pending_high;
  logic [7:0]  ver_len;
  logic [15:0] total_field;
  logic [15:0] frag_field;
  logic [7:0]  proto_byte;
  logic [31:0] src_word;
  logic [31:0] dst_word;

  logic [15:0] count_next;
  logic [15:0] sum_next;
  logic [7:0]  ver_len_next;
  logic [15:0] total_next;
  logic [15:0] frag_next;
  logic [7:0]  proto_next;
  logic [31:0] src_next;
  logic [31:0] dst_next;
  logic [5:0]  hlen;
  logic        in_header;
  logic [15:0] word_in;
  logic [15:0] final_sum;
  status_t     status_next;

  assign advance  = vld && (!last_reg || !out_valid || out_ready);
  assign in_ready = !vld || advance;

  always_comb begin
    ver_len_next = ver_len;
    total_next   = total_field;
    frag_next    = frag_field;
    proto_next   = proto_byte;
    src_next     = src_word;
    dst_next     = dst_word;
    unique case (byte_count)
      16'd0: begin
        ver_len_next = byte_reg;
      end
      16'd2, 16'd3: begin
        total_next = {total_field[7:0], byte_reg};
      end
      16'd6, 16'd7: begin
        frag_next = {frag_field[7:0], byte_reg};
      end
      16'd9: begin
        proto_next = byte_reg;
      end
      16'd12, 16'd13, 16'd14, 16'd15: begin
        src_next = {src_word[23:0], byte_reg};
      end
      16'd16, 16'd17, 16'd18, 16'd19: begin
        dst_next = {dst_word[23:0], byte_reg};
      end
      default: begin
      end
    endcase

    hlen      = {ver_len_next[3:0], 2'b00};
    in_header = byte_count < {10'd0, hlen};
    // odd offset completes a word; an even offset on the final byte is
    // folded in as a high half with a zero low half
    word_in   = byte_count[0] ? {pending_high, byte_reg} : {byte_reg, 8'h00};
    sum_next  = oc_add(sum_acc, word_in);
    final_sum = in_header ? sum_next : sum_acc;

    count_next = (byte_count != COUNT_MAX) ? (byte_count + 16'd1) : byte_count;

    priority if (count_next < MIN_HEADER_BYTES) begin
      status_next = STATUS_SHORT;
    end else if (final_sum != CSUM_GOOD) begin
      status_next = STATUS_CHECKSUM;
    end else if (ver_len_next[7:4] != IP_VERSION) begin
      status_next = STATUS_VERSION;
    end else if (count_next < {10'd0, hlen}) begin
      status_next = STATUS_HDR_LEN;
    end else if (count_next < total_next) begin
      status_next = STATUS_TOTAL_LEN;
    end else if ((frag_next & (MORE_FRAGMENTS | OFFSET_MASK)) != 16'd0) begin
      status_next = STATUS_FRAGMENT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (advance) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= data_byte;
      last_reg <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last_reg)) begin
      byte_count   <= 16'd0;
      sum_acc      <= 16'd0;
      pending_high <= 8'd0;
      ver_len      <= 8'd0;
      total_field  <= 16'd0;
      frag_field   <= 16'd0;
      proto_byte   <= 8'd0;
      src_word     <= 32'd0;
      dst_word     <= 32'd0;
    end else if (advance) begin
      byte_count  <= count_next;
      ver_len     <= ver_len_next;
      total_field <= total_next;
      frag_field  <= frag_next;
      proto_byte  <= proto_next;
      src_word    <= src_next;
      dst_word    <= dst_next;
      if (in_header) begin
        if (byte_count[0]) begin
          sum_acc <= sum_next;
        end else begin
          pending_high <= byte_reg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_reg) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_reg) begin
      status              <= status_next;
      protocol            <= proto_next;
      total_length        <= total_next;
      header_length       <= hlen;
      source_address      <= src_next;
      destination_address <= dst_next;
    end
  end

  // a final byte leaving the input register always yields a result
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && last_reg) |=> out_valid)
    else $error("final byte produced no result");

  // any non-final byte leaves a nonzero count behind
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (advance && !last_reg) |=> (byte_count != 16'd0))
    else $error("byte count did not advance");

  // input is only held off while the input register is occupied
  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (vld && last_reg && out_valid))
    else $error("input stalled without a pending result");

  // a result never reports an undefined status code
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 3'd7))
    else $error("undefined status code");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv4 header checker.
// ----------------------------------------------------------------------------
// Builds IPv4 packets, some well formed with a valid header checksum, the
// rest with one chosen fault or random bytes, and streams them a byte per
// transaction. A byte-level tracker predicts the verdict and fields of each
// packet as bytes are accepted. The monitor compares every result
// transaction with the oldest prediction. Both sides idle in random bursts.
// One phase holds off the result side for a long stretch, and the closing
// phase runs with no idling at all.

module testbench;
  import ihc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD      = 400;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } link_byte_t;

  typedef struct {
    status_t     status;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [5:0]  header_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } verdict_t;

  typedef enum {
    PK_GOOD, PK_BAD_SUM, PK_BAD_VERSION, PK_TRUNC_HDR, PK_TRUNC_TOTAL,
    PK_FRAGMENT, PK_SHORT, PK_SMALL_IHL, PK_NOISE
  } pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  protocol;
  logic [15:0] total_length;
  logic [5:0]  header_length;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  link_byte_t  byte_queue[$];
  verdict_t    pending_verdicts[$];
  link_byte_t  next_byte;
  int unsigned bytes_queued = 0;
  int unsigned failures = 0;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned idle_cycles = 0;
  bit          src_idle_en = 1'b0;
  bit          sink_idle_en = 1'b0;

  // per-packet tracker state
  logic [15:0] trk_count;
  logic [15:0] trk_sum;
  logic [7:0]  trk_pending;
  logic [7:0]  trk_vl;
  logic [15:0] trk_total;
  logic [15:0] trk_frag;
  logic [7:0]  trk_proto;
  logic [31:0] trk_src;
  logic [31:0] trk_dst;

  ipv4_header_checker dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .data_byte           (data_byte),
    .last_byte           (last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .protocol            (protocol),
    .total_length        (total_length),
    .header_length       (header_length),
    .source_address      (source_address),
    .destination_address (destination_address)
  );

  always #5 clk = ~clk;

  // 16-bit ones-complement add, end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_tracker();
    trk_count   = '0;
    trk_sum     = '0;
    trk_pending = '0;
    trk_vl      = '0;
    trk_total   = '0;
    trk_frag    = '0;
    trk_proto   = '0;
    trk_src     = '0;
    trk_dst     = '0;
  endtask

  task automatic track_byte(input logic [7:0] b, input logic fin);
    logic [15:0] pos;
    logic [5:0]  hlen;
    logic [15:0] hlen_wide;
    logic [15:0] covered;
    logic [15:0] sum;
    verdict_t    v;
    pos = trk_count;
    case (pos)
      16'd0:                        trk_vl = b;
      16'd2, 16'd3:                 trk_total = {trk_total[7:0], b};
      16'd6, 16'd7:                 trk_frag = {trk_frag[7:0], b};
      16'd9:                        trk_proto = b;
      16'd12, 16'd13, 16'd14, 16'd15: trk_src = {trk_src[23:0], b};
      16'd16, 16'd17, 16'd18, 16'd19: trk_dst = {trk_dst[23:0], b};
      default: ;
    endcase
    hlen = {trk_vl[3:0], 2'b00};
    hlen_wide = {10'd0, hlen};
    if (pos < hlen_wide) begin
      if (pos[0]) trk_sum = ones_add(trk_sum, {trk_pending, b});
      else trk_pending = b;
    end
    trk_count = (pos != COUNT_MAX) ? pos + 16'd1 : pos;
    if (fin) begin
      covered = (trk_count < hlen_wide) ? trk_count : hlen_wide;
      sum = trk_sum;
      // odd count of covered header bytes: dangling byte is the high half of a zero-padded word
      if (covered[0]) sum = ones_add(sum, {trk_pending, 8'h00});
      if (trk_count < MIN_HEADER_BYTES) v.status = STATUS_SHORT;
      else if (sum != CSUM_GOOD) v.status = STATUS_CHECKSUM;
      else if (trk_vl[7:4] != IP_VERSION) v.status = STATUS_VERSION;
      else if (trk_count < hlen_wide) v.status = STATUS_HDR_LEN;
      else if (trk_count < trk_total) v.status = STATUS_TOTAL_LEN;
      else if ((trk_frag & (MORE_FRAGMENTS | OFFSET_MASK)) != 16'd0)
        v.status = STATUS_FRAGMENT;
      else v.status = STATUS_OK;
      v.protocol            = trk_proto;
      v.total_length        = trk_total;
      v.header_length       = hlen;
      v.source_address      = trk_src;
      v.destination_address = trk_dst;
      pending_verdicts.push_back(v);
      clear_tracker();
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      failures++;
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual status %0d", $time, status);
      failures++;
    end else begin
      want = pending_verdicts.pop_front();
      check_field("status", 32'(want.status), 32'(status));
      check_field("protocol", 32'(want.protocol), 32'(protocol));
      check_field("total_length", 32'(want.total_length), 32'(total_length));
      check_field("header_length", 32'(want.header_length), 32'(header_length));
      check_field("source_address", want.source_address, source_address);
      check_field("destination_address", want.destination_address, destination_address);
    end
  endtask

  task automatic push_byte(input logic [7:0] d, input logic fin);
    link_byte_t lb;
    lb.data = d;
    lb.last = fin;
    byte_queue.push_back(lb);
    bytes_queued++;
  endtask

  // ihl_pick of zero lets the packet kind choose the header length
  task automatic push_packet(input pkt_kind_t kind, input int unsigned payload,
                             input int unsigned ihl_pick);
    logic [7:0]  hdr [60];
    int unsigned ihl, hbytes, base, total, len, covered, i;
    logic [15:0] tot_fld, frag, acc, csum;
    logic [3:0]  version;
    if (kind == PK_NOISE) begin
      len = $urandom_range(1, 60);
      for (i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
      return;
    end
    for (i = 0; i < 60; i++) hdr[i] = 8'($urandom);
    if (ihl_pick != 0) ihl = ihl_pick;
    else if (kind == PK_SMALL_IHL) ihl = $urandom_range(0, 4);
    else if (kind == PK_TRUNC_HDR) ihl = $urandom_range(6, 15);
    else ihl = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
    hbytes = ihl * 4;
    base = (hbytes < 20) ? 20 : hbytes;
    if (kind == PK_TRUNC_TOTAL && payload == 0) payload = 1;
    total = base + payload;
    case (kind)
      PK_SHORT:       len = $urandom_range(1, 19);
      PK_TRUNC_HDR:   len = $urandom_range(20, hbytes - 1);
      PK_TRUNC_TOTAL: len = $urandom_range(base, total - 1);
      default:        len = total + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
    endcase
    tot_fld = (total > 65535) ? 16'hffff : total[15:0];
    if (kind == PK_TRUNC_TOTAL && $urandom_range(0, 2) == 0)
      tot_fld = 16'($urandom_range(len + 1, 65535));
    version = IP_VERSION;
    if (kind == PK_BAD_VERSION) begin
      version = 4'($urandom_range(0, 14));
      if (version >= IP_VERSION) version = version + 4'd1;
    end
    // top two flag bits random half the time, more-fragments and offset clear
    frag = {($urandom_range(0, 1) != 0) ? 2'($urandom) : 2'b00, 14'd0};
    if (kind == PK_FRAGMENT) begin
      if ($urandom_range(0, 1)) frag = frag | MORE_FRAGMENTS;
      else frag = (frag & ~OFFSET_MASK) | 16'($urandom_range(1, 8191));
    end
    hdr[0] = {version, ihl[3:0]};
    hdr[2] = tot_fld[15:8];
    hdr[3] = tot_fld[7:0];
    hdr[6] = frag[15:8];
    hdr[7] = frag[7:0];
    // checksum over the header bytes the checker will actually see
    covered = (len < hbytes) ? len : hbytes;
    hdr[10] = 8'h00;
    hdr[11] = 8'h00;
    acc = '0;
    for (i = 0; i < covered; i += 2)
      acc = ones_add(acc, {hdr[i], (i + 1 < covered) ? hdr[i + 1] : 8'h00});
    csum = ~acc;
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    if (kind == PK_BAD_SUM) begin
      i = $urandom_range(0, covered - 1);
      hdr[i] = hdr[i] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (i = 0; i < len; i++)
      push_byte((i < 60) ? hdr[i] : 8'($urandom), i == len - 1);
  endtask

  function automatic pkt_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return PK_GOOD;
    if (r < 50) return PK_BAD_SUM;
    if (r < 58) return PK_BAD_VERSION;
    if (r < 66) return PK_TRUNC_HDR;
    if (r < 74) return PK_TRUNC_TOTAL;
    if (r < 82) return PK_FRAGMENT;
    if (r < 88) return PK_SHORT;
    if (r < 94) return PK_SMALL_IHL;
    return PK_NOISE;
  endfunction

  task automatic fill_random(input int unsigned n);
    int unsigned target;
    int unsigned payload;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      payload = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      push_packet(pick_kind(), payload, 0);
    end
  endtask

  // sender stays quiet until every predicted result has come back
  task automatic wait_for_drain();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || pending_verdicts.size() != 0);
  endtask

  // byte driver; the tracker sees each byte as its transaction completes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
      clear_tracker();
    end else begin
      if (in_valid && in_ready) track_byte(data_byte, last_byte);
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (src_idle_en && byte_queue.size() != 0 && $urandom_range(0, 11) == 0) begin
          src_gap  <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          next_byte = byte_queue.pop_front();
          in_valid  <= 1'b1;
          data_byte <= next_byte.data;
          last_byte <= next_byte.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (out_valid && out_ready) check_verdict();
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        sink_hold    <= LONG_HOLD;
        out_ready    <= 1'b0;
      end else if (sink_hold != 0) begin
        sink_hold <= sink_hold - 1;
        out_ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        sink_hold <= $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: one-byte packet, all-zero short packet, minimal good header
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_packet(PK_GOOD, 0, 5);
    wait_for_drain();

    fill_random(500);
    wait_for_drain();

    // result side held off while small packets keep coming
    src_idle_en = 1'b0;
    hold_requests++;
    for (int k = 0; k < 12; k++) push_packet(PK_GOOD, 0, 5);
    wait_for_drain();

    fill_random(350);
    wait_for_drain();

    // closing stretch with no idling on either side
    sink_idle_en = 1'b0;
    fill_random(350);
    wait_for_drain();

    repeat (8) @(posedge clk);
    if (failures == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
